@@ design/twa_pkg.sv @@
// shared types, constants and sizes for the touch wheel angle block
package twa_pkg;

	localparam int SAMPLES_PER_ELECTRODE = 10;
	localparam int ELECTRODES = 3;
	localparam int SUM_W = $clog2(SAMPLES_PER_ELECTRODE * 255 + 1);
	localparam int WITHIN_W = (SAMPLES_PER_ELECTRODE > 1) ? $clog2(SAMPLES_PER_ELECTRODE) : 1;
	localparam int WHICH_W = $clog2(ELECTRODES);
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP = ((1 << RECIP_SHIFT) + SAMPLES_PER_ELECTRODE - 1) / SAMPLES_PER_ELECTRODE;
	localparam int RECIP_W = RECIP_SHIFT + 1;

	localparam logic [8:0] SPAN_DEG = 9'd120;
	localparam logic [8:0] FULL_DEG = 9'd360;
	localparam logic [7:0] THRESHOLD_RESET = 8'd20;

	localparam int DVD_W = 15;
	localparam int CNT_W = $clog2(DVD_W);
	localparam int QUOT_W = 7;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PAIR_12,
		PAIR_13,
		PAIR_23
	} pair_t;

	typedef struct packed {
		logic touched;
		pair_t pair;
		logic [7:0] num;
		logic [8:0] den;
	} cls_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} b_state_t;

endpackage

@@ design/twa_front.sv @@
// front end: sample accumulation, group averages and pair classification
module twa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic [7:0]          threshold,
	input  logic                q_full,
	output logic                q_push,
	output twa_pkg::cls_t       q_data
);

	logic [twa_pkg::SUM_W-1:0] sum_q;
	logic [twa_pkg::WITHIN_W-1:0] within_q;
	logic [twa_pkg::WHICH_W-1:0] which_q;
	logic [7:0] avg_q [twa_pkg::ELECTRODES];
	logic pend_s1;

	logic accept;
	logic last_in;
	logic [twa_pkg::SUM_W-1:0] sum_nx;
	logic [twa_pkg::SUM_W+twa_pkg::RECIP_W-1:0] prod;
	logic [7:0] avg_new;
	logic [8:0] s12, s13, s23;
	logic below;

	assign s_tready = !(pend_s1 && q_full);
	assign accept = s_tvalid && s_tready;
	assign sum_nx = sum_q + twa_pkg::SUM_W'(s_tdata);
	assign last_in = within_q == twa_pkg::WITHIN_W'(twa_pkg::SAMPLES_PER_ELECTRODE - 1);
	assign prod = (twa_pkg::SUM_W+twa_pkg::RECIP_W)'(sum_nx)
		* (twa_pkg::SUM_W+twa_pkg::RECIP_W)'(twa_pkg::RECIP);
	assign avg_new = 8'(prod >> twa_pkg::RECIP_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			within_q <= '0;
			which_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (q_push) begin
				pend_s1 <= 1'b0;
			end
			if (accept) begin
				if (last_in) begin
					sum_q <= '0;
					within_q <= '0;
					if (which_q == twa_pkg::WHICH_W'(twa_pkg::ELECTRODES - 1)) begin
						which_q <= '0;
						pend_s1 <= 1'b1;
					end else begin
						which_q <= which_q + 1'b1;
					end
				end else begin
					sum_q <= sum_nx;
					within_q <= within_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_in) begin
			avg_q[which_q] <= avg_new;
		end
	end

	// pair sums and touch decision from the finished averages
	assign s12 = {1'b0, avg_q[0]} + {1'b0, avg_q[1]};
	assign s13 = {1'b0, avg_q[0]} + {1'b0, avg_q[2]};
	assign s23 = {1'b0, avg_q[1]} + {1'b0, avg_q[2]};
	assign below = (avg_q[0] < threshold) && (avg_q[1] < threshold) && (avg_q[2] < threshold);
	assign q_push = pend_s1 && !q_full;

	always_comb begin
		q_data.touched = !below;
		priority if (s12 > s23 && s12 > s13) begin
			q_data.pair = twa_pkg::PAIR_12;
			q_data.num = avg_q[1];
			q_data.den = s12;
		end else if (s13 > s12 && s13 > s23) begin
			q_data.pair = twa_pkg::PAIR_13;
			q_data.num = avg_q[2];
			q_data.den = s13;
		end else begin
			q_data.pair = twa_pkg::PAIR_23;
			q_data.num = avg_q[2];
			q_data.den = s23;
		end
	end

endmodule

@@ design/twa_queue.sv @@
// short queue of classified frames between front and back end
module twa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  twa_pkg::cls_t wr_data,
	input  logic          pop,
	output twa_pkg::cls_t rd_data,
	output logic          full,
	output logic          empty
);

	twa_pkg::cls_t mem_q [twa_pkg::QDEPTH];
	logic [twa_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [twa_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [twa_pkg::QCNT_W-1:0] cnt_q;

	assign full = cnt_q == twa_pkg::QCNT_W'(twa_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule

@@ design/twa_back.sv @@
// back end: serial proportion divider and angle result register
module twa_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  twa_pkg::cls_t q_data,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic          m_tuser
);

	twa_pkg::b_state_t state_q, state_nx;
	twa_pkg::pair_t pair_q;
	logic touched_q;
	logic [8:0] den_q;
	logic [8:0] rem_q;
	logic [twa_pkg::DVD_W-1:0] dvd_q;
	logic [twa_pkg::CNT_W-1:0] cnt_q;
	logic [8:0] angle_q;

	logic [9:0] trial;
	logic ge;
	logic [8:0] rem_nx;
	logic [twa_pkg::DVD_W-1:0] dvd_nx;
	logic [twa_pkg::DVD_W-1:0] dvd_load;
	logic start_div;

	function automatic logic [8:0] place(twa_pkg::pair_t p, logic [twa_pkg::QUOT_W-1:0] q);
		logic [8:0] qx;
		logic [8:0] r;
		qx = {2'b00, q};
		unique case (p)
			twa_pkg::PAIR_12: r = qx;
			twa_pkg::PAIR_13: r = twa_pkg::FULL_DEG - qx;
			twa_pkg::PAIR_23: r = twa_pkg::SPAN_DEG + qx;
			default: r = twa_pkg::SPAN_DEG + qx;
		endcase
		return r;
	endfunction

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[twa_pkg::DVD_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign rem_nx = ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
	assign dvd_nx = {dvd_q[twa_pkg::DVD_W-2:0], ge};

	// ceiling for the pair 1/3 case
	assign dvd_load = twa_pkg::DVD_W'(q_data.num) * twa_pkg::DVD_W'(twa_pkg::SPAN_DEG)
		+ ((q_data.pair == twa_pkg::PAIR_13) ? twa_pkg::DVD_W'(q_data.den - 9'd1) : '0);
	assign start_div = q_data.touched && (q_data.den != '0);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			twa_pkg::B_IDLE: begin
				if (!q_empty) begin
					state_nx = start_div ? twa_pkg::B_DIV : twa_pkg::B_DONE;
				end
			end
			twa_pkg::B_DIV: begin
				if (cnt_q == '0) begin
					state_nx = twa_pkg::B_DONE;
				end
			end
			twa_pkg::B_DONE: begin
				if (m_tready) begin
					state_nx = twa_pkg::B_IDLE;
				end
			end
			default: state_nx = twa_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == twa_pkg::B_IDLE) && !q_empty;
		m_tvalid = state_q == twa_pkg::B_DONE;
		m_tdata = {7'd0, angle_q};
		m_tuser = touched_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twa_pkg::B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			twa_pkg::B_IDLE: begin
				if (!q_empty) begin
					pair_q <= q_data.pair;
					touched_q <= q_data.touched;
					den_q <= q_data.den;
					rem_q <= '0;
					dvd_q <= dvd_load;
					cnt_q <= twa_pkg::CNT_W'(twa_pkg::DVD_W - 1);
					angle_q <= q_data.touched ? place(q_data.pair, '0) : '0;
				end
			end
			twa_pkg::B_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_nx;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					angle_q <= place(pair_q, dvd_nx[twa_pkg::QUOT_W-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twa_pkg::B_DONE && !touched_q) |-> angle_q == '0)
		else $error("untouched result with nonzero angle");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twa_pkg::B_DIV) |-> (den_q != '0 && touched_q))
		else $error("division started without a valid divisor");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == twa_pkg::B_DONE) |-> angle_q <= twa_pkg::FULL_DEG)
		else $error("angle out of range");

endmodule

@@ design/touch_wheel_angle.sv @@
// top level of the three-electrode touch wheel angle block
// usage:
//  s_* channel takes one 8-bit electrode sample per beat, samples in fixed order:
//  a group for electrode one, then electrode two, then electrode three
//  the front end takes one beat every cycle, except while the queue is full
//  and a finished frame waits, and averages each group as it ends; after the
//  last sample of electrode three the frame is classified and queued; the
//  back end divides one quotient bit per cycle, then holds the result on m_*
//  until taken; results come one per frame of samples
//  m_tdata carries the angle, m_tuser the touched flag
//  a stalled receiver holds the back end; the two-entry queue and the front
//  keep taking samples until the queue is full and a further frame is waiting
//  cfg_we writes the touch threshold, write only while the block is idle
//  reset clears counters, queue and back end state; threshold returns to 20
module touch_wheel_angle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // reading[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // angle[8:0], zeros
	output logic        m_tuser,   // touched
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0] threshold_q;
	logic q_push, q_pop, q_full, q_empty;
	twa_pkg::cls_t q_wr, q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= twa_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	twa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.threshold (threshold_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr)
	);

	twa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	twa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the touch wheel angle block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN = twa_pkg::ELECTRODES * twa_pkg::SAMPLES_PER_ELECTRODE;
	localparam int RANDOM_FRAMES = 8;
	localparam int IDLE_PAUSE = 30;
	localparam int HOLD_AT_READING = 700;
	localparam int HOLD_CYCLES = 500;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       touched;
		logic [8:0] angle;
	} wheel_result_t;

	class wheel_angle_tracker;
		logic [7:0] threshold;
		int unsigned group_sum;
		int unsigned sample_pos;
		int unsigned averages [twa_pkg::ELECTRODES];
		wheel_result_t expected_angles [$];
		int unsigned errors;

		function new();
			threshold = twa_pkg::THRESHOLD_RESET;
			group_sum = 0;
			sample_pos = 0;
			foreach (averages[i]) averages[i] = 0;
			errors = 0;
		endfunction

		function int unsigned wheel_position(int unsigned a1, int unsigned a2,
				int unsigned a3);
			int unsigned s12;
			int unsigned s23;
			int unsigned s13;
			int unsigned span;
			s12 = a1 + a2;
			s23 = a2 + a3;
			s13 = a1 + a3;
			span = int'(twa_pkg::SPAN_DEG);
			if (s12 > s23 && s12 > s13)
				return (span * a2) / s12;
			if (s13 > s12 && s13 > s23)
				return int'(twa_pkg::FULL_DEG) - (span * a3 + s13 - 1) / s13;
			if (s23 == 0)
				return span;
			return span + (span * a3) / s23;
		endfunction

		function void take_reading(logic [7:0] reading);
			int unsigned group_pos;
			int unsigned which;
			wheel_result_t res;
			group_sum += reading;
			group_pos = sample_pos % twa_pkg::SAMPLES_PER_ELECTRODE;
			which = sample_pos / twa_pkg::SAMPLES_PER_ELECTRODE;
			if (group_pos + 1 < twa_pkg::SAMPLES_PER_ELECTRODE) begin
				sample_pos++;
				return;
			end
			averages[which] = group_sum / twa_pkg::SAMPLES_PER_ELECTRODE;
			group_sum = 0;
			if (which + 1 < twa_pkg::ELECTRODES) begin
				sample_pos++;
				return;
			end
			sample_pos = 0;
			if (averages[0] < threshold && averages[1] < threshold &&
					averages[2] < threshold) begin
				res.touched = 1'b0;
				res.angle = '0;
			end else begin
				res.touched = 1'b1;
				res.angle = 9'(wheel_position(averages[0], averages[1], averages[2]));
			end
			expected_angles.push_back(res);
		endfunction

		function void compare_result(logic touched, logic [8:0] angle);
			wheel_result_t exp_res;
			if (expected_angles.size() == 0) begin
				$error("result beat with nothing expected: touched %0d angle %0d",
					touched, angle);
				errors++;
				return;
			end
			exp_res = expected_angles.pop_front();
			if (touched !== exp_res.touched) begin
				$error("touched: expected %0d, actual %0d", exp_res.touched, touched);
				errors++;
			end
			if (angle !== exp_res.angle) begin
				$error("angle: expected %0d, actual %0d", exp_res.angle, angle);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;

	wheel_angle_tracker tracker = new();
	logic [7:0] frame_buf [FRAME_LEN];
	int burst_left = 0;
	int readings_taken = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int rx_mode = 0;
	int mode_left = 0;

	touch_wheel_angle DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cfg_we)
			tracker.threshold = cfg_wdata;
		if (s_tvalid && s_tready) begin
			tracker.take_reading(s_tdata);
			readings_taken++;
		end
		if (m_tvalid && m_tready)
			tracker.compare_result(m_tuser, m_tdata[8:0]);
	end

	// receiver: own stall pattern plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (!hold_done && readings_taken >= HOLD_AT_READING) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	function automatic logic [7:0] clip(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	function automatic void fill_group(int e, int level, int spread);
		for (int i = 0; i < twa_pkg::SAMPLES_PER_ELECTRODE; i++)
			frame_buf[e * twa_pkg::SAMPLES_PER_ELECTRODE + i] =
				clip(level + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	task automatic send_frame();
		int gap;
		for (int i = 0; i < FRAME_LEN; i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
			s_tvalid <= 1'b1;
			s_tdata <= frame_buf[i];
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			@(negedge clk);
			burst_left--;
		end
	endtask

	task automatic flat_frame(int a1, int a2, int a3);
		fill_group(0, a1, 0);
		fill_group(1, a2, 0);
		fill_group(2, a3, 0);
		send_frame();
	endtask

	task automatic random_frame();
		int style;
		int thr;
		thr = tracker.threshold;
		for (int e = 0; e < twa_pkg::ELECTRODES; e++) begin
			style = $urandom_range(0, 9);
			case (style)
				0: for (int i = 0; i < twa_pkg::SAMPLES_PER_ELECTRODE; i++)
					frame_buf[e * twa_pkg::SAMPLES_PER_ELECTRODE + i] =
						8'($urandom_range(0, 255));
				1, 2: fill_group(e, thr + int'($urandom_range(0, 6)) - 3,
					$urandom_range(0, 2));
				3: fill_group(e, 0, $urandom_range(0, 1));
				4: fill_group(e, 255, $urandom_range(0, 1));
				5: if (e > 0) begin
					for (int i = 0; i < twa_pkg::SAMPLES_PER_ELECTRODE; i++)
						frame_buf[e * twa_pkg::SAMPLES_PER_ELECTRODE + i] =
							frame_buf[(e - 1) * twa_pkg::SAMPLES_PER_ELECTRODE + i];
				end else begin
					fill_group(e, $urandom_range(0, 255), 0);
				end
				default: fill_group(e, $urandom_range(0, 255), $urandom_range(0, 20));
			endcase
		end
		send_frame();
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.expected_angles.size() != 0) @(negedge clk);
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	task automatic write_threshold(logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] thresholds [5];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed frames at the reset threshold
		flat_frame(0, 0, 0);
		flat_frame(255, 255, 255);
		fill_group(0, 20, 0);
		frame_buf[0] = 8'd19;
		fill_group(1, 19, 0);
		fill_group(2, 0, 0);
		send_frame();
		flat_frame(20, 0, 0);
		flat_frame(100, 50, 0);
		flat_frame(100, 0, 33);
		flat_frame(0, 50, 100);
		flat_frame(0, 0, 255);
		flat_frame(255, 0, 1);
		flat_frame(1, 0, 255);
		wait_idle();

		thresholds[0] = 8'd0;
		thresholds[1] = 8'd255;
		thresholds[2] = 8'($urandom_range(0, 255));
		thresholds[3] = 8'd1;
		thresholds[4] = 8'($urandom_range(0, 255));
		for (int p = 0; p < 5; p++) begin
			write_threshold(thresholds[p]);
			if (p == 0)
				flat_frame(0, 0, 0);
			if (p == 1) begin
				flat_frame(255, 255, 255);
				flat_frame(254, 254, 254);
			end
			for (int f = 0; f < RANDOM_FRAMES; f++)
				random_frame();
			wait_idle();
		end

		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
